[hw/rtl/gpc_pkg.sv]
// Shared constants and types for the grid path counter.
`default_nettype none

package gpc_pkg;

  // Coordinate and count widths
  localparam int COORD_BITS = 4;
  localparam int COUNT_BITS = 48;
  localparam int CELLS      = 1 << COORD_BITS;

  // Stream payload widths (whole bytes)
  localparam int IN_FIELDS_BITS = 4 * COORD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELDS_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((COUNT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD1 = 4'b0010,
    ST_ADD2 = 4'b0100,
    ST_DONE = 4'b1000
  } gpc_state_t;

  // Datapath control from the sequencer
  typedef struct packed {
    logic                  add1;       // first add: right + below
    logic                  add2;       // second add: partial + diagonal, store
    logic                  clear;      // zero the result (no path possible)
    logic                  seed;       // cell is the exit: value one
    logic                  use_right;
    logic                  use_below;
    logic                  use_diag;
    logic [COORD_BITS-1:0] col;
  } gpc_dp_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/gpc_sat_add.sv]
// Shared saturating adder for the path counts.
`default_nettype none

module gpc_sat_add (
  input  wire logic [gpc_pkg::COUNT_BITS-1:0] op_a,
  input  wire logic [gpc_pkg::COUNT_BITS-1:0] op_b,
  output logic      [gpc_pkg::COUNT_BITS-1:0] sum
);

  logic [gpc_pkg::COUNT_BITS:0] raw;

  // Add with carry out, clamp on overflow
  always_comb begin
    raw = {1'b0, op_a} + {1'b0, op_b};
    sum = raw[gpc_pkg::COUNT_BITS] ? gpc_pkg::COUNT_MAX : raw[gpc_pkg::COUNT_BITS-1:0];
  end

endmodule

`default_nettype wire

[hw/rtl/gpc_dp.sv]
// Path count datapath: row buffer, operand registers and the shared adder.
`default_nettype none

module gpc_dp (
  input  wire logic                           clk,
  input  wire gpc_pkg::gpc_dp_ctl_t           ctl,
  output logic      [gpc_pkg::COUNT_BITS-1:0] count
);

  // Counts of the row below, indexed by column
  logic [gpc_pkg::COUNT_BITS-1:0] row_r [gpc_pkg::CELLS];
  logic [gpc_pkg::COUNT_BITS-1:0] acc_r, acc_nxt;
  logic [gpc_pkg::COUNT_BITS-1:0] right_r;
  logic [gpc_pkg::COUNT_BITS-1:0] diag_r;
  logic [gpc_pkg::COUNT_BITS-1:0] below;
  logic [gpc_pkg::COUNT_BITS-1:0] op_a, op_b, sum;

  // Pick adder operands for the current phase
  always_comb begin
    below = row_r[ctl.col];
    if (ctl.add1) begin
      if (ctl.seed) begin
        op_a = gpc_pkg::COUNT_ONE;
      end else begin
        op_a = ctl.use_right ? right_r : '0;
      end
      op_b = ctl.use_below ? below : '0;
    end else begin
      op_a = acc_r;
      op_b = ctl.use_diag ? diag_r : '0;
    end
  end

  gpc_sat_add u_add (
    .op_a (op_a),
    .op_b (op_b),
    .sum  (sum)
  );

  // Hold the partial sum, zero it when no path exists
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.add1 || ctl.add2) begin
      acc_nxt = sum;
    end
  end

  // Store the finished cell, keep the old entry as the next diagonal
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.add2) begin
      row_r[ctl.col] <= sum;
      right_r        <= sum;
      diag_r         <= below;
    end
  end

  assign count = acc_r;

endmodule

`default_nettype wire

[hw/rtl/gpc_ctrl.sv]
// Sequencer: walks the grid cells from the exit back to the start.
`default_nettype none

module gpc_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           req_valid,
  input  wire logic [gpc_pkg::COORD_BITS-1:0] start_row,
  input  wire logic [gpc_pkg::COORD_BITS-1:0] start_col,
  input  wire logic [gpc_pkg::COORD_BITS-1:0] exit_row,
  input  wire logic [gpc_pkg::COORD_BITS-1:0] exit_col,
  input  wire logic                           out_free,
  output logic                                req_ready,
  output logic                                deliver,
  output gpc_pkg::gpc_dp_ctl_t                ctl
);

  gpc_pkg::gpc_state_t state_r, state_nxt;
  logic [gpc_pkg::COORD_BITS-1:0] a_r, a_nxt;
  logic [gpc_pkg::COORD_BITS-1:0] b_r, b_nxt;
  logic [gpc_pkg::COORD_BITS-1:0] m_r, m_nxt;
  logic [gpc_pkg::COORD_BITS-1:0] n_r, n_nxt;
  logic                           has_path;

  // A path exists only when the exit lies below-right and is not the start
  assign has_path = (exit_row >= start_row) && (exit_col >= start_col) &&
                    !((exit_row == start_row) && (exit_col == start_col));

  // Next state and cell position
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    n_nxt     = n_r;
    req_ready = 1'b0;
    deliver   = 1'b0;

    ctl           = '0;
    ctl.col       = b_r;
    ctl.seed      = (a_r == m_r) && (b_r == n_r);
    ctl.use_right = (b_r != n_r);
    ctl.use_below = (a_r != m_r);
    ctl.use_diag  = (b_r != n_r) && (a_r != m_r);

    case (state_r)
      gpc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (has_path) begin
            m_nxt     = exit_row - start_row;
            n_nxt     = exit_col - start_col;
            a_nxt     = exit_row - start_row;
            b_nxt     = exit_col - start_col;
            state_nxt = gpc_pkg::ST_ADD1;
          end else begin
            ctl.clear = 1'b1;
            state_nxt = gpc_pkg::ST_DONE;
          end
        end
      end
      gpc_pkg::ST_ADD1: begin
        ctl.add1  = 1'b1;
        state_nxt = gpc_pkg::ST_ADD2;
      end
      gpc_pkg::ST_ADD2: begin
        ctl.add2 = 1'b1;
        // Advance right to left, then up one row
        if (b_r == '0) begin
          if (a_r == '0) begin
            state_nxt = gpc_pkg::ST_DONE;
          end else begin
            a_nxt     = a_r - 1'b1;
            b_nxt     = n_r;
            state_nxt = gpc_pkg::ST_ADD1;
          end
        end else begin
          b_nxt     = b_r - 1'b1;
          state_nxt = gpc_pkg::ST_ADD1;
        end
      end
      gpc_pkg::ST_DONE: begin
        // Hand the count over once the output slot is free
        if (out_free) begin
          deliver   = 1'b1;
          state_nxt = gpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    m_r <= m_nxt;
    n_r <= n_nxt;
  end

  // Each first add is followed by its second add
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gpc_pkg::ST_ADD1) |=> (state_r == gpc_pkg::ST_ADD2))
    else $error("first add not followed by second add");

  // The walk stays inside the rectangle between start and exit
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gpc_pkg::ST_ADD1) || (state_r == gpc_pkg::ST_ADD2)) |->
    ((a_r <= m_r) && (b_r <= n_r)))
    else $error("cell position outside the grid");

  // A finished count waits while the output slot is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gpc_pkg::ST_DONE) && !out_free) |=> (state_r == gpc_pkg::ST_DONE))
    else $error("count dropped while output busy");

endmodule

`default_nettype wire

[hw/rtl/grid_path_count_backtracking.sv]
// Top level of the grid path counter: stream ports and output register.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+----------------
//  in_      | request   | start_row, start_col, exit_row, exit_col    | -
//  out_     | result    | path_count                                  | count_saturated
//
//  For an item with a path, R and C being the row and column distance to the
//  exit, one shared adder does two adds per grid cell over (R+1)*(C+1) cells.
//  An item with no path (start on or past the exit) skips the adds and yields zero.
//  in_tready is high only while the sequencer is idle; the output register lets
//  the next request in while a result waits for out_tready.
//  Synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module grid_path_count_backtracking (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // start_row[3:0], start_col[7:4], exit_row[11:8], exit_col[15:12]
  input  wire logic [gpc_pkg::IN_DATA_BITS-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // path_count[47:0]
  output logic      [gpc_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // count_saturated[0]
  output logic      [0:0]                        out_tuser
);

  localparam int CB = gpc_pkg::COORD_BITS;

  logic                             out_valid_r;
  logic [gpc_pkg::COUNT_BITS-1:0]   out_count_r;
  logic                             out_sat_r;
  logic                             out_free;
  logic                             deliver;
  logic [gpc_pkg::COUNT_BITS-1:0]   count;
  gpc_pkg::gpc_dp_ctl_t             ctl;

  assign out_free = !out_valid_r || out_tready;

  gpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .start_row (in_tdata[CB-1:0]),
    .start_col (in_tdata[2*CB-1:CB]),
    .exit_row  (in_tdata[3*CB-1:2*CB]),
    .exit_col  (in_tdata[4*CB-1:3*CB]),
    .out_free  (out_free),
    .req_ready (in_tready),
    .deliver   (deliver),
    .ctl       (ctl)
  );

  gpc_dp u_dp (
    .clk   (clk),
    .ctl   (ctl),
    .count (count)
  );

  // Output valid: set on delivery, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the count and its saturation flag
  always_ff @(posedge clk) begin
    if (deliver) begin
      out_count_r <= count;
      out_sat_r   <= (count == gpc_pkg::COUNT_MAX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = gpc_pkg::OUT_DATA_BITS'(out_count_r);
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire
